/* hdl/sts_pkg.sv */
package sts_pkg;
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int KEY_W = 32;
  localparam int DATA_W = 8;
  localparam int OUT_W = 6;
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;
endpackage

/* hdl/sts_cell.sv */
module sts_cell
  import sts_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [KEY_W-1:0]  key_in,
  input  logic [DATA_W-1:0] data_in,
  input  logic [KEY_W-1:0]  prev_key,
  input  logic [DATA_W-1:0] prev_data,
  output logic [KEY_W-1:0]  key,
  output logic [DATA_W-1:0] data
);
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key <= key_in;
      data <= data_in;
    end else if (ctl.shift) begin
      key <= prev_key;
      data <= prev_data;
    end
  end
endmodule

/* hdl/sorted_table_search_insert.sv */
// Sorted table of up to TABLE_DEPTH signed keys with a data byte each, kept in
// ascending order in a row of register cells. Each request runs a binary
// search, one probe per cycle (one key compare through a read mux). The result
// is registered in S_DONE once the search ends on a hit or on an empty range,
// and a new request is taken only in idle with no result waiting on out_ready.
// An insert shifts all later cells up by one in the same cycle as it writes
// the new key. Inserts into a full table are dropped and flagged.
module sorted_table_search_insert
  import sts_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  output logic                    ready,
  input  logic                    kind,
  input  logic signed [KEY_W-1:0] key,
  input  logic [DATA_W-1:0]       item_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    found,
  output logic [OUT_W-1:0]        position,
  output logic [DATA_W-1:0]       found_data,
  output logic                    table_full,
  output logic [OUT_W-1:0]        entry_count
);
  localparam int CW = $clog2(TABLE_DEPTH + 2);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [1:0] S_IDLE = 2'd0, S_SRCH = 2'd1, S_DONE = 2'd2;

  logic [1:0] state;
  logic [CW-1:0] count, low, high, hit;
  logic req_kind;
  logic signed [KEY_W-1:0] req_key;
  logic [DATA_W-1:0] req_data;
  logic [KEY_W-1:0] keys [TABLE_DEPTH];
  logic [DATA_W-1:0] datas [TABLE_DEPTH];
  cell_ctl_t ctl [TABLE_DEPTH];

  logic [CW:0] sum;
  logic [CW-1:0] mid, pos;
  logic [IW-1:0] midx;
  logic signed [KEY_W-1:0] mkey;
  logic is_full, do_ins;

  assign sum = {1'b0, low} + {1'b0, high};
  assign mid = sum[CW:1];
  assign midx = IW'(mid - CW'(1));
  assign mkey = keys[midx];
  assign is_full = (count == CW'(TABLE_DEPTH));
  assign pos = (hit != '0) ? hit : low;
  assign do_ins = (state == S_DONE) && (req_kind == KIND_INSERT) && !is_full;
  assign ready = (state == S_IDLE) && !(out_valid && !out_ready);

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      assign ctl[g].load = do_ins && (CW'(g + 1) == pos);
      assign ctl[g].shift = do_ins && (CW'(g + 1) > pos) && (CW'(g) < count + CW'(1));
      sts_cell u_cell (
        .clk(clk), .ctl(ctl[g]), .key_in(req_key), .data_in(req_data),
        .prev_key(keys[(g == 0) ? 0 : g - 1]),
        .prev_data(datas[(g == 0) ? 0 : g - 1]),
        .key(keys[g]), .data(datas[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (valid && ready) begin
            req_kind <= kind;
            req_key <= key;
            req_data <= item_data;
            low <= CW'(1);
            high <= count;
            hit <= '0;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (low > high) begin
            state <= S_DONE;
          end else if (mkey == req_key) begin
            hit <= mid;
            state <= S_DONE;
          end else if (mkey > req_key) begin
            high <= mid - CW'(1);
          end else begin
            low <= mid + CW'(1);
          end
        end
        S_DONE: begin
          found <= (hit != '0);
          out_valid <= 1'b1;
          if (req_kind == KIND_LOOKUP) begin
            position <= OUT_W'(hit);
            found_data <= (hit != '0) ? datas[IW'(hit - CW'(1))] : '0;
            table_full <= 1'b0;
            entry_count <= OUT_W'(count);
          end else if (is_full) begin
            position <= '0;
            found_data <= '0;
            table_full <= 1'b1;
            entry_count <= OUT_W'(count);
          end else begin
            position <= OUT_W'(pos);
            found_data <= '0;
            table_full <= 1'b0;
            entry_count <= OUT_W'(count + CW'(1));
            count <= count + CW'(1);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH)) else $error("count over depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CW'(1)))
    else $error("count jumped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !ready) else $error("ready while busy");
endmodule
